// ===== design/ir_pulse_width_capture_macros.svh =====
// Assertion macros for the pulse width capture block.
`ifndef IR_PULSE_WIDTH_CAPTURE_MACROS_SVH
`define IR_PULSE_WIDTH_CAPTURE_MACROS_SVH

// Same-cycle implication.
`define PWC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pulse width capture: same-cycle check failed");

// Next-cycle implication.
`define PWC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pulse width capture: next-cycle check failed");

`endif

// ===== design/pwc_pkg.sv =====
`default_nettype none
package pwc_pkg;

    localparam int MAX_PULSES = 128;
    localparam int IDX_W      = $clog2(MAX_PULSES);
    localparam int CNT_W      = 8;
    localparam int DUR_W      = 16;
    localparam int ELAPSED_W  = 32;
    localparam int THR_W      = 16;
    localparam int TMO_W      = 19;
    localparam int CFG_DATA_W = 19;
    localparam int CFG_IDX_W  = 1;
    localparam int CMD_W      = 2;
    localparam int RIDX_W     = 7;

    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EDGE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_END_GAP_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_TIMEOUT       = 1'b1;

    localparam logic [THR_W-1:0] END_GAP_RESET = 16'd3000;
    localparam logic [TMO_W-1:0] TIMEOUT_RESET = 19'd262144;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [RIDX_W-1:0] read_index;
    } pwc_req_t;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } pwc_cfg_wr_t;

endpackage
`default_nettype wire

// ===== design/pwc_core.sv =====
`default_nettype none
module pwc_core
    import pwc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire pwc_cfg_wr_t       cfg_wr,
    input  wire logic              proc_en,
    input  wire pwc_req_t          req,
    output logic                   data_available,
    output logic                   has_error,
    output logic [CNT_W-1:0]       pulse_count,
    output logic [DUR_W-1:0]       read_value
);

    logic [THR_W-1:0]     end_gap_reg;
    logic [TMO_W-1:0]     timeout_reg;

    logic                 started_reg, started_next;
    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next;
    logic                 armed_reg, armed_next;
    logic                 finished_reg, finished_next;
    logic                 error_reg, error_next;
    logic [CNT_W-1:0]     count_reg, count_next;

    logic                 data_available_reg;
    logic                 has_error_reg;
    logic [CNT_W-1:0]     pulse_count_reg;
    logic [DUR_W-1:0]     read_value_reg;

    logic [DUR_W-1:0]     mem [MAX_PULSES];
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_widx;
    logic [IDX_W-1:0]     mem_ridx;
    logic                 rd_hit;
    logic [ELAPSED_W-1:0] elapsed_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_gap_reg <= END_GAP_RESET;
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_wr.we)
        begin
            case (cfg_wr.index)
                CFG_END_GAP_THRESHOLD: end_gap_reg <= cfg_wr.data[THR_W-1:0];
                CFG_GAP_TIMEOUT:       timeout_reg <= cfg_wr.data[TMO_W-1:0];
                default:               ;
            endcase
        end
    end

    assign elapsed_inc = (elapsed_reg == {ELAPSED_W{1'b1}}) ? elapsed_reg
                                                            : elapsed_reg + 1'b1;
    assign mem_widx = count_reg[IDX_W-1:0];
    assign mem_ridx = req.read_index[IDX_W-1:0];
    assign rd_hit   = (req.command == CMD_READ)
                   && ({{(CNT_W-RIDX_W){1'b0}}, req.read_index} < count_reg);

    always_comb
    begin
        started_next  = started_reg;
        elapsed_next  = elapsed_reg;
        armed_next    = armed_reg;
        finished_next = finished_reg;
        error_next    = error_reg;
        count_next    = count_reg;
        mem_we        = 1'b0;
        case (req.command)
            CMD_TICK:
            begin
                if (started_reg)
                begin
                    elapsed_next = elapsed_inc;
                    if (armed_reg && elapsed_inc >= {{(ELAPSED_W-TMO_W){1'b0}}, timeout_reg})
                    begin
                        error_next = 1'b1;
                        armed_next = 1'b0;
                    end
                end
            end
            CMD_EDGE:
            begin
                if (!finished_reg && !error_reg)
                begin
                    if (!started_reg)
                    begin
                        started_next = 1'b1;
                        elapsed_next = '0;
                        armed_next   = 1'b0;
                    end
                    else if (count_reg >= CNT_W'(MAX_PULSES))
                    begin
                        error_next = 1'b1;
                        armed_next = 1'b0;
                    end
                    else
                    begin
                        mem_we       = 1'b1;
                        count_next   = count_reg + 1'b1;
                        elapsed_next = '0;
                        armed_next   = 1'b1;
                        if (elapsed_reg >= {{(ELAPSED_W-THR_W){1'b0}}, end_gap_reg})
                        begin
                            finished_next = 1'b1;
                            armed_next    = 1'b0;
                        end
                    end
                end
            end
            CMD_CLEAR:
            begin
                started_next  = 1'b0;
                elapsed_next  = '0;
                armed_next    = 1'b0;
                finished_next = 1'b0;
                error_next    = 1'b0;
                count_next    = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg  <= 1'b0;
            elapsed_reg  <= '0;
            armed_reg    <= 1'b0;
            finished_reg <= 1'b0;
            error_reg    <= 1'b0;
            count_reg    <= '0;
        end
        else if (proc_en)
        begin
            started_reg  <= started_next;
            elapsed_reg  <= elapsed_next;
            armed_reg    <= armed_next;
            finished_reg <= finished_next;
            error_reg    <= error_next;
            count_reg    <= count_next;
        end
    end

    // result fields show the state after the request
    always_ff @(posedge clk)
    begin
        if (proc_en)
        begin
            data_available_reg <= finished_next && !error_next;
            has_error_reg      <= error_next;
            pulse_count_reg    <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_en && mem_we)
            mem[mem_widx] <= elapsed_reg[DUR_W-1:0];
        if (proc_en)
            read_value_reg <= rd_hit ? mem[mem_ridx] : '0;
    end

    assign data_available = data_available_reg;
    assign has_error      = has_error_reg;
    assign pulse_count    = pulse_count_reg;
    assign read_value     = read_value_reg;

endmodule
`default_nettype wire

// ===== design/ir_pulse_width_capture.sv =====
// ir_pulse_width_capture
// Input channel: in_valid/in_stall with command and read_index; one request
// per cycle while in_stall is low: tick (1 us), edge, clear, or read of one stored duration.
// Output channel: out_valid/out_stall with data_available, has_error,
// pulse_count and read_value; exactly one result per request, showing the
// capture state after that request.
// Path: the input register holds the request, then the state update and the
// registered pulse store read land in the result register that drives
// out_valid.
// Throughput: 1 request per cycle, sustained, with out_stall low.
// Configuration: cfg_we, cfg_index (0 end gap threshold, 1 gap timeout),
// cfg_data; write only while no request is in flight.
// Reset: clears capture state and the pipeline, loads threshold 3000 and
// timeout 262144. The pulse store needs no clearing; reads stop at the count.
// Stall: a held result freezes the pipeline; in_stall rises once the input
// register is also full, and nothing is dropped.
`default_nettype none
`include "ir_pulse_width_capture_macros.svh"
module ir_pulse_width_capture
    import pwc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [CMD_W-1:0]      command,
    input  wire logic [RIDX_W-1:0]     read_index,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       data_available,
    output logic                       has_error,
    output logic [CNT_W-1:0]           pulse_count,
    output logic [DUR_W-1:0]           read_value
);

    logic        s1_valid_reg;
    pwc_req_t    s1_req_reg;
    logic        out_valid_reg;
    logic        advance;
    pwc_cfg_wr_t cfg_wr;

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;
    assign cfg_wr   = '{we: cfg_we, index: cfg_index, data: cfg_data};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                s1_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            s1_req_reg <= '{command: command, read_index: read_index};
    end

    pwc_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr         (cfg_wr),
        .proc_en        (s1_valid_reg && advance),
        .req            (s1_req_reg),
        .data_available (data_available),
        .has_error      (has_error),
        .pulse_count    (pulse_count),
        .read_value     (read_value)
    );

    assign out_valid = out_valid_reg;

    `PWC_ASSERT_NOW(a_stall_when_full, clk, rst_n,
        s1_valid_reg && out_valid_reg && out_stall, in_stall)
    `PWC_ASSERT_NEXT(a_request_moves, clk, rst_n,
        s1_valid_reg && !out_stall, out_valid)
    `PWC_ASSERT_NOW(a_flags_exclusive, clk, rst_n,
        out_valid, !(data_available && has_error))
    `PWC_ASSERT_NOW(a_count_bound, clk, rst_n,
        out_valid, pulse_count <= CNT_W'(MAX_PULSES))

endmodule
`default_nettype wire
